// ----- sv/assert_macros.svh -----
// assertion macros used by the checker in aclp_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition that must hold at every clock edge out of reset
`define CHK_HOLDS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("port check failed");

// same-cycle implication
`define CHK_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("port check failed");

// next-cycle implication
`define CHK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("port check failed");

`endif

// ----- sv/aclp_pkg.sv -----
package aclp_pkg;

    localparam int LINE_BYTES_DEF  = 256;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [3:0] CMD_PTT      = 4'd0;
    localparam logic [3:0] CMD_TG       = 4'd1;
    localparam logic [3:0] CMD_LOCK     = 4'd2;
    localparam logic [3:0] CMD_MUTE     = 4'd3;
    localparam logic [3:0] CMD_VOLUME   = 4'd4;
    localparam logic [3:0] CMD_STATUS   = 4'd5;
    localparam logic [3:0] CMD_QUIT     = 4'd6;
    localparam logic [3:0] CMD_UNKNOWN  = 4'd7;
    localparam logic [3:0] CMD_NOT_NUM  = 4'd8;
    localparam logic [3:0] CMD_OVERLONG = 4'd9;

    localparam logic [1:0] SW_OFF    = 2'd0;
    localparam logic [1:0] SW_ON     = 2'd1;
    localparam logic [1:0] SW_TOGGLE = 2'd2;

    localparam logic [1:0] STEP_ABS  = 2'd0;
    localparam logic [1:0] STEP_NEXT = 2'd1;
    localparam logic [1:0] STEP_PREV = 2'd2;

    localparam logic [7:0] CH_NL    = 8'd10;
    localparam logic [7:0] CH_NUL   = 8'd0;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_HASH  = 8'd35;
    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;
    localparam logic [7:0] CH_UP_A  = 8'd65;
    localparam logic [7:0] CH_UP_Z  = 8'd90;

    localparam int NWORDS = 10;
    localparam logic [31:0] VOL_MAX = 32'd200;

    // verb indexes
    localparam int V_PTT    = 0;
    localparam int V_TG     = 1;
    localparam int V_LOCK   = 2;
    localparam int V_MUTE   = 3;
    localparam int V_UNMUTE = 4;
    localparam int V_VOLUME = 5;
    localparam int V_VOL    = 6;
    localparam int V_STATUS = 7;
    localparam int V_QUIT   = 8;
    localparam int V_EXIT   = 9;

    // argument word indexes
    localparam int A_ON    = 0;
    localparam int A_ONE   = 1;
    localparam int A_YES   = 2;
    localparam int A_TRUE  = 3;
    localparam int A_OFF   = 4;
    localparam int A_ZERO  = 5;
    localparam int A_NO    = 6;
    localparam int A_FALSE = 7;
    localparam int A_NEXT  = 8;
    localparam int A_PREV  = 9;

    typedef logic [47:0] word_t;
    typedef logic [2:0]  pos_t;
    typedef logic [NWORDS-1:0] cand_t;

    // words are left aligned, first character in the top byte
    localparam word_t VERB_TEXT [NWORDS] = '{
        {"ptt", 24'h0}, {"tg", 32'h0}, {"lock", 16'h0}, {"mute", 16'h0}, "unmute",
        "volume", {"vol", 24'h0}, "status", {"quit", 16'h0}, {"exit", 16'h0}
    };
    localparam pos_t VERB_LEN [NWORDS] = '{3'd3, 3'd2, 3'd4, 3'd4, 3'd6,
                                           3'd6, 3'd3, 3'd6, 3'd4, 3'd4};

    localparam word_t ARG_TEXT [NWORDS] = '{
        {"on", 32'h0}, {"1", 40'h0}, {"yes", 24'h0}, {"true", 16'h0}, {"off", 24'h0},
        {"0", 40'h0}, {"no", 32'h0}, {"false", 8'h0}, {"next", 16'h0}, {"prev", 16'h0}
    };
    localparam pos_t ARG_LEN [NWORDS] = '{3'd2, 3'd1, 3'd3, 3'd4, 3'd3,
                                          3'd1, 3'd2, 3'd5, 3'd4, 3'd4};

    typedef enum logic [2:0] {
        PH_LEAD,
        PH_SKIP,
        PH_VERB,
        PH_VERB_WS,
        PH_ARG,
        PH_DONE
    } phase_t;

    typedef struct packed {
        logic [7:0] ch;
        logic [7:0] lc;
        logic       ws;
        logic       sep;
        logic       nl;
        logic       nul;
        logic       digit;
        logic       overlong;
    } tok_t;

    typedef struct packed {
        logic [3:0]  command;
        logic [1:0]  switch_value;
        logic [1:0]  group_step;
        logic [31:0] number;
        logic        mute_on;
    } res_t;

    function automatic logic [7:0] char_at(input word_t w, input pos_t p);
        word_t sh;
        sh = w << {p, 3'b000};
        return sh[47:40];
    endfunction

    function automatic pos_t pos_inc(input pos_t p);
        return (p == 3'd7) ? p : p + 3'd1;
    endfunction

    function automatic cand_t verb_step(input cand_t c, input pos_t p, input logic [7:0] ch);
        cand_t r;
        for (int i = 0; i < NWORDS; i++)
        begin
            r[i] = c[i] && (p < VERB_LEN[i]) && (char_at(VERB_TEXT[i], p) == ch);
        end
        return r;
    endfunction

    function automatic cand_t arg_step(input cand_t c, input pos_t p, input logic [7:0] ch);
        cand_t r;
        for (int i = 0; i < NWORDS; i++)
        begin
            r[i] = c[i] && (p < ARG_LEN[i]) && (char_at(ARG_TEXT[i], p) == ch);
        end
        return r;
    endfunction

    function automatic cand_t verb_hits(input cand_t c, input pos_t p);
        cand_t r;
        for (int i = 0; i < NWORDS; i++)
        begin
            r[i] = c[i] && (p == VERB_LEN[i]);
        end
        return r;
    endfunction

    function automatic cand_t arg_hits(input cand_t c, input pos_t p);
        cand_t r;
        for (int i = 0; i < NWORDS; i++)
        begin
            r[i] = c[i] && (p == ARG_LEN[i]);
        end
        return r;
    endfunction

endpackage

// ----- sv/aclp_queue.sv -----
module aclp_queue #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         wr_en,
    input  logic [W-1:0] wdata,
    output logic         q_full,
    input  logic         rd_en,
    output logic [W-1:0] rdata,
    output logic         q_empty
);
    localparam int AW = $clog2(DEPTH);

    logic [W-1:0] mem_reg [DEPTH];
    logic [AW:0]  wr_ptr_reg, wr_ptr_next;
    logic [AW:0]  rd_ptr_reg, rd_ptr_next;
    logic         do_wr, do_rd;

    assign q_empty = (wr_ptr_reg == rd_ptr_reg);
    assign q_full  = (wr_ptr_reg[AW-1:0] == rd_ptr_reg[AW-1:0]) &&
                     (wr_ptr_reg[AW] != rd_ptr_reg[AW]);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rdata   = mem_reg[rd_ptr_reg[AW-1:0]];

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg[AW-1:0]] <= wdata;
        end
    end
endmodule

// ----- sv/aclp_front.sv -----
module aclp_front #(
    parameter int LINE_BYTES = aclp_pkg::LINE_BYTES_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  logic [7:0]     byte_in,
    input  logic           tok_full,
    output logic           tok_wr,
    output aclp_pkg::tok_t tok
);
    localparam int CW = $clog2(LINE_BYTES);

    logic [CW-1:0] count_reg, count_next;
    logic          accept;
    logic          limit;

    assign accept = push && !tok_full;
    assign tok_wr = accept;
    assign limit  = (count_reg >= CW'(LINE_BYTES - 2));

    always_comb
    begin
        tok.ch       = byte_in;
        tok.lc       = ((byte_in >= aclp_pkg::CH_UP_A) && (byte_in <= aclp_pkg::CH_UP_Z)) ?
                       byte_in + 8'd32 : byte_in;
        tok.ws       = (byte_in == aclp_pkg::CH_SPACE) ||
                       ((byte_in >= aclp_pkg::CH_TAB) && (byte_in <= aclp_pkg::CH_CR));
        tok.sep      = (byte_in == aclp_pkg::CH_SPACE) || (byte_in == aclp_pkg::CH_TAB);
        tok.nl       = (byte_in == aclp_pkg::CH_NL);
        tok.nul      = (byte_in == aclp_pkg::CH_NUL);
        tok.digit    = (byte_in >= aclp_pkg::CH_ZERO) && (byte_in <= aclp_pkg::CH_NINE);
        tok.overlong = !tok.nl && limit;

        count_next = count_reg;
        if (accept)
        begin
            if (tok.nl || limit)
            begin
                count_next = '0;
            end
            else
            begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end
endmodule

// ----- sv/aclp_back.sv -----
module aclp_back (
    input  logic           clk,
    input  logic           rst_n,
    input  aclp_pkg::tok_t tok,
    input  logic           tok_empty,
    output logic           tok_rd,
    input  logic           res_full,
    output logic           res_wr,
    output aclp_pkg::res_t res
);
    aclp_pkg::phase_t phase_reg, phase_next;
    aclp_pkg::cand_t  vcand_reg, vcand_next;
    aclp_pkg::pos_t   vpos_reg, vpos_next;
    aclp_pkg::cand_t  acand_reg, acand_next;
    aclp_pkg::pos_t   apos_reg, apos_next;
    logic             sep_seen_reg, sep_seen_next;
    logic             taint_reg, taint_next;
    logic             arg_ws_reg, arg_ws_next;
    logic             arg_seen_reg, arg_seen_next;
    logic [63:0]      acc_reg, acc_next;
    logic             num_any_reg, num_any_next;
    logic             num_stop_reg, num_stop_next;
    logic             neg_reg, neg_next;
    logic             sat_reg, sat_next;

    logic             emit;
    logic             do_arg;
    aclp_pkg::cand_t  vh, ah;
    aclp_pkg::res_t   dec;
    logic [67:0]      prod;
    logic [31:0]      low_word;
    logic [1:0]       sw;

    assign tok_rd = !tok_empty && !res_full;
    assign res_wr = tok_rd && emit;

    // line decode from the held match state
    always_comb
    begin
        vh       = aclp_pkg::verb_hits(vcand_reg, vpos_reg);
        ah       = aclp_pkg::arg_hits(acand_reg, apos_reg);
        low_word = sat_reg ? 32'hFFFF_FFFF : (neg_reg ? 32'd0 - acc_reg[31:0] : acc_reg[31:0]);
        if (ah[aclp_pkg::A_ON] || ah[aclp_pkg::A_ONE] || ah[aclp_pkg::A_YES] ||
            ah[aclp_pkg::A_TRUE])
        begin
            sw = aclp_pkg::SW_ON;
        end
        else if (ah[aclp_pkg::A_OFF] || ah[aclp_pkg::A_ZERO] || ah[aclp_pkg::A_NO] ||
                 ah[aclp_pkg::A_FALSE])
        begin
            sw = aclp_pkg::SW_OFF;
        end
        else
        begin
            sw = aclp_pkg::SW_TOGGLE;
        end

        dec = '0;
        priority if (vh[aclp_pkg::V_PTT])
        begin
            dec.command      = aclp_pkg::CMD_PTT;
            dec.switch_value = sw;
        end
        else if (vh[aclp_pkg::V_TG])
        begin
            dec.command = aclp_pkg::CMD_TG;
            priority if (ah[aclp_pkg::A_NEXT])
                dec.group_step = aclp_pkg::STEP_NEXT;
            else if (ah[aclp_pkg::A_PREV])
                dec.group_step = aclp_pkg::STEP_PREV;
            else if (num_any_reg)
                dec.number = low_word;
            else
                dec.command = aclp_pkg::CMD_NOT_NUM;
        end
        else if (vh[aclp_pkg::V_LOCK])
        begin
            dec.command      = aclp_pkg::CMD_LOCK;
            dec.switch_value = sw;
        end
        else if (vh[aclp_pkg::V_MUTE] || vh[aclp_pkg::V_UNMUTE])
        begin
            if (num_any_reg)
            begin
                dec.command = aclp_pkg::CMD_MUTE;
                dec.number  = low_word;
                dec.mute_on = vh[aclp_pkg::V_MUTE];
            end
            else
            begin
                dec.command = aclp_pkg::CMD_NOT_NUM;
            end
        end
        else if (vh[aclp_pkg::V_VOLUME] || vh[aclp_pkg::V_VOL])
        begin
            if (num_any_reg)
            begin
                dec.command = aclp_pkg::CMD_VOLUME;
                if (neg_reg)
                    dec.number = '0;
                else if (acc_reg > {32'd0, aclp_pkg::VOL_MAX})
                    dec.number = aclp_pkg::VOL_MAX;
                else
                    dec.number = acc_reg[31:0];
            end
            else
            begin
                dec.command = aclp_pkg::CMD_NOT_NUM;
            end
        end
        else if (vh[aclp_pkg::V_STATUS])
        begin
            dec.command = aclp_pkg::CMD_STATUS;
        end
        else if (vh[aclp_pkg::V_QUIT] || vh[aclp_pkg::V_EXIT])
        begin
            dec.command = aclp_pkg::CMD_QUIT;
        end
        else
        begin
            dec.command = aclp_pkg::CMD_UNKNOWN;
        end
    end

    // per-byte state update
    always_comb
    begin
        phase_next    = phase_reg;
        vcand_next    = vcand_reg;
        vpos_next     = vpos_reg;
        acand_next    = acand_reg;
        apos_next     = apos_reg;
        sep_seen_next = sep_seen_reg;
        taint_next    = taint_reg;
        arg_ws_next   = arg_ws_reg;
        arg_seen_next = arg_seen_reg;
        acc_next      = acc_reg;
        num_any_next  = num_any_reg;
        num_stop_next = num_stop_reg;
        neg_next      = neg_reg;
        sat_next      = sat_reg;
        emit          = 1'b0;
        res           = dec;
        do_arg        = 1'b0;
        prod          = ({4'd0, acc_reg} << 3) + ({4'd0, acc_reg} << 1) +
                        {60'd0, tok.ch[3:0]};

        if (tok.overlong || tok.nl)
        begin
            if (tok.overlong)
            begin
                emit        = 1'b1;
                res         = '0;
                res.command = aclp_pkg::CMD_OVERLONG;
            end
            else
            begin
                emit = (phase_reg != aclp_pkg::PH_LEAD) && (phase_reg != aclp_pkg::PH_SKIP);
            end
            phase_next    = aclp_pkg::PH_LEAD;
            vcand_next    = '1;
            vpos_next     = '0;
            acand_next    = '1;
            apos_next     = '0;
            sep_seen_next = 1'b0;
            taint_next    = 1'b0;
            arg_ws_next   = 1'b0;
            arg_seen_next = 1'b0;
            acc_next      = '0;
            num_any_next  = 1'b0;
            num_stop_next = 1'b0;
            neg_next      = 1'b0;
            sat_next      = 1'b0;
        end
        else
        begin
            unique case (phase_reg)
                aclp_pkg::PH_LEAD:
                begin
                    if (tok.nul || tok.ch == aclp_pkg::CH_HASH)
                    begin
                        phase_next = aclp_pkg::PH_SKIP;
                    end
                    else if (!tok.ws)
                    begin
                        phase_next = aclp_pkg::PH_VERB;
                        vcand_next = aclp_pkg::verb_step(vcand_reg, vpos_reg, tok.lc);
                        vpos_next  = aclp_pkg::pos_inc(vpos_reg);
                    end
                end
                aclp_pkg::PH_VERB:
                begin
                    if (tok.nul)
                    begin
                        phase_next = aclp_pkg::PH_DONE;
                    end
                    else if (tok.ws)
                    begin
                        phase_next    = aclp_pkg::PH_VERB_WS;
                        sep_seen_next = tok.sep;
                        taint_next    = !tok.sep;
                    end
                    else
                    begin
                        vcand_next = aclp_pkg::verb_step(vcand_reg, vpos_reg, tok.lc);
                        vpos_next  = aclp_pkg::pos_inc(vpos_reg);
                    end
                end
                aclp_pkg::PH_VERB_WS:
                begin
                    if (tok.nul)
                    begin
                        phase_next = aclp_pkg::PH_DONE;
                    end
                    else if (tok.ws)
                    begin
                        if (!sep_seen_reg)
                        begin
                            sep_seen_next = tok.sep;
                            taint_next    = 1'b1;
                        end
                    end
                    else if (sep_seen_reg)
                    begin
                        // other white space before the separator belongs to the verb
                        if (taint_reg)
                            vcand_next = '0;
                        phase_next = aclp_pkg::PH_ARG;
                        do_arg     = 1'b1;
                    end
                    else
                    begin
                        // white space inside the verb, no verb can match
                        phase_next = aclp_pkg::PH_VERB;
                        vcand_next = '0;
                        vpos_next  = aclp_pkg::pos_inc(vpos_reg);
                    end
                end
                aclp_pkg::PH_ARG:
                begin
                    if (tok.nul)
                    begin
                        phase_next = aclp_pkg::PH_DONE;
                    end
                    else if (tok.ws)
                    begin
                        arg_ws_next   = 1'b1;
                        num_stop_next = 1'b1;
                    end
                    else
                    begin
                        do_arg = 1'b1;
                    end
                end
                aclp_pkg::PH_SKIP, aclp_pkg::PH_DONE:
                begin
                end
                default:
                begin
                    phase_next = aclp_pkg::PH_LEAD;
                end
            endcase

            if (do_arg)
            begin
                acand_next    = aclp_pkg::arg_step(arg_ws_reg ? '0 : acand_reg, apos_reg, tok.lc);
                apos_next     = aclp_pkg::pos_inc(apos_reg);
                arg_seen_next = 1'b1;
                if (!num_stop_reg)
                begin
                    if (!arg_seen_reg &&
                        (tok.ch == aclp_pkg::CH_PLUS || tok.ch == aclp_pkg::CH_MINUS))
                    begin
                        neg_next = (tok.ch == aclp_pkg::CH_MINUS);
                    end
                    else if (tok.digit)
                    begin
                        num_any_next = 1'b1;
                        if (sat_reg || prod[67:64] != 4'd0)
                        begin
                            sat_next = 1'b1;
                            acc_next = '1;
                        end
                        else
                        begin
                            acc_next = prod[63:0];
                        end
                    end
                    else
                    begin
                        num_stop_next = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= aclp_pkg::PH_LEAD;
            vcand_reg    <= '1;
            vpos_reg     <= '0;
            acand_reg    <= '1;
            apos_reg     <= '0;
            sep_seen_reg <= 1'b0;
            taint_reg    <= 1'b0;
            arg_ws_reg   <= 1'b0;
            arg_seen_reg <= 1'b0;
            acc_reg      <= '0;
            num_any_reg  <= 1'b0;
            num_stop_reg <= 1'b0;
            neg_reg      <= 1'b0;
            sat_reg      <= 1'b0;
        end
        else if (tok_rd)
        begin
            phase_reg    <= phase_next;
            vcand_reg    <= vcand_next;
            vpos_reg     <= vpos_next;
            acand_reg    <= acand_next;
            apos_reg     <= apos_next;
            sep_seen_reg <= sep_seen_next;
            taint_reg    <= taint_next;
            arg_ws_reg   <= arg_ws_next;
            arg_seen_reg <= arg_seen_next;
            acc_reg      <= acc_next;
            num_any_reg  <= num_any_next;
            num_stop_reg <= num_stop_next;
            neg_reg      <= neg_next;
            sat_reg      <= sat_next;
        end
    end
endmodule

// ----- sv/ascii_command_line_parser_unit.sv -----
// channel   | transfer when    | fields
// ----------+------------------+-----------------------------------------------
// input     | push && !full    | byte_in
// result    | pop && !empty    | command switch_value group_step number mute_on
//
// one byte per cycle sustained while full stays low; a result becomes visible once its newline
// has passed through the byte queue and then the result queue
// reset clears the line counter, parser state and both queues
// a held result (pop low) fills the result queue, then the byte queue, then full rises
module ascii_command_line_parser_unit #(
    parameter int LINE_BYTES  = aclp_pkg::LINE_BYTES_DEF,
    parameter int QUEUE_DEPTH = aclp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  byte_in,
    output logic        empty,
    input  logic        pop,
    output logic [3:0]  command,
    output logic [1:0]  switch_value,
    output logic [1:0]  group_step,
    output logic [31:0] number,
    output logic        mute_on
);
    localparam int TW = $bits(aclp_pkg::tok_t);
    localparam int RW = $bits(aclp_pkg::res_t);

    aclp_pkg::tok_t tok_in, tok_out;
    aclp_pkg::res_t res_in, res_out;
    logic           tok_wr, tok_rd, tok_full, tok_empty;
    logic           res_wr, res_full;

    assign full = tok_full;

    aclp_front #(.LINE_BYTES(LINE_BYTES)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .byte_in  (byte_in),
        .tok_full (tok_full),
        .tok_wr   (tok_wr),
        .tok      (tok_in)
    );

    aclp_queue #(.W(TW), .DEPTH(QUEUE_DEPTH)) u_tok_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (tok_wr),
        .wdata   (tok_in),
        .q_full  (tok_full),
        .rd_en   (tok_rd),
        .rdata   (tok_out),
        .q_empty (tok_empty)
    );

    aclp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok       (tok_out),
        .tok_empty (tok_empty),
        .tok_rd    (tok_rd),
        .res_full  (res_full),
        .res_wr    (res_wr),
        .res       (res_in)
    );

    aclp_queue #(.W(RW), .DEPTH(QUEUE_DEPTH)) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_wr),
        .wdata   (res_in),
        .q_full  (res_full),
        .rd_en   (pop),
        .rdata   (res_out),
        .q_empty (empty)
    );

    assign command      = res_out.command;
    assign switch_value = res_out.switch_value;
    assign group_step   = res_out.group_step;
    assign number       = res_out.number;
    assign mute_on      = res_out.mute_on;
endmodule

// ----- sv/aclp_checker.sv -----
`include "assert_macros.svh"

module aclp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        push,
    input logic        full,
    input logic [7:0]  byte_in,
    input logic        empty,
    input logic        pop,
    input logic [3:0]  command,
    input logic [1:0]  switch_value,
    input logic [1:0]  group_step,
    input logic [31:0] number,
    input logic        mute_on
);
    logic shown;
    logic is_err;
    logic in_xfer;

    assign shown   = !empty;
    assign is_err  = (command == aclp_pkg::CMD_UNKNOWN) || (command == aclp_pkg::CMD_NOT_NUM) ||
                     (command == aclp_pkg::CMD_OVERLONG);
    assign in_xfer = push && !full && (byte_in == aclp_pkg::CH_NL);

    `CHK_IMPLIES(a_code_range, shown && !in_xfer, command <= aclp_pkg::CMD_OVERLONG)
    `CHK_IMPLIES(a_err_clean, shown && is_err,
                 switch_value == 2'd0 && group_step == 2'd0 && number == 32'd0 && !mute_on)
    `CHK_IMPLIES(a_vol_clamp, shown && command == aclp_pkg::CMD_VOLUME,
                 number <= aclp_pkg::VOL_MAX)
    `CHK_IMPLIES(a_switch_only, shown && command != aclp_pkg::CMD_PTT &&
                 command != aclp_pkg::CMD_LOCK, switch_value == aclp_pkg::SW_OFF)
    `CHK_NEXT(a_hold, shown && !pop, !empty && $stable(command) && $stable(number))
endmodule

bind ascii_command_line_parser_unit aclp_checker u_aclp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .byte_in      (byte_in),
    .empty        (empty),
    .pop          (pop),
    .command      (command),
    .switch_value (switch_value),
    .group_step   (group_step),
    .number       (number),
    .mute_on      (mute_on)
);
